>>> rtl/tphs_pkg.sv
// shared types, constants and control store for the tilt peak-hold smoother
`timescale 1ns / 1ps

package tphs_pkg;

	// fixed field and state widths
	localparam int SAMPLE_W       = 16;
	localparam int ELAPSED_W      = 16;
	localparam int POS_W          = 24;
	localparam int POS_EXTRA_BITS = 8;
	localparam int FAC_W          = 17;
	localparam int MUL_A_W        = 26;
	localparam int MUL_B_W        = 18;
	localparam int PROD_W         = MUL_A_W + MUL_B_W;

	// Q16 unity and Q32 per-millisecond ratios for the factor tables
	localparam logic [FAC_W-1:0] ONE_Q16        = 17'h10000;
	localparam logic [31:0]      DECAY_RATIO_Q32 = 32'd4252231657;
	localparam logic [31:0]      BLEND_RATIO_Q32 = 32'd4266429413;

	// configuration register indexes
	localparam logic [1:0] CFG_MIN_HALF_WIDTH = 2'd0;
	localparam logic [1:0] CFG_BAR_LIMIT      = 2'd1;
	localparam logic [1:0] CFG_PEAK_CAP       = 2'd2;

	// configuration reset values
	localparam logic [7:0]  MIN_HALF_WIDTH_RST = 8'd13;
	localparam logic [9:0]  BAR_LIMIT_RST      = 10'd200;
	localparam logic [14:0] PEAK_CAP_RST       = 15'd8192;

	// control store addresses
	localparam logic [2:0] STEP_IDLE     = 3'd0;
	localparam logic [2:0] STEP_FETCH    = 3'd1;
	localparam logic [2:0] STEP_AX_DECAY = 3'd2;
	localparam logic [2:0] STEP_AX_BLEND = 3'd3;
	localparam logic [2:0] STEP_AX_POS   = 3'd4;
	localparam logic [2:0] STEP_AX_SCALE = 3'd5;
	localparam logic [2:0] STEP_AX_HALF  = 3'd6;
	localparam logic [2:0] STEP_AX_EMIT  = 3'd7;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_NONE  = 3'd0,
		MUL_DECAY = 3'd1,
		MUL_BLEND = 3'd2,
		MUL_MAG   = 3'd3,
		MUL_HALF  = 3'd4
	} mul_sel_t;

	// sequencing kinds
	typedef enum logic [1:0] {
		JMP_NEXT  = 2'd0,
		JMP_START = 2'd1,
		JMP_EMIT  = 2'd2
	} jump_t;

	// one control word
	typedef struct packed {
		mul_sel_t    mul;
		logic        ld_fac;
		logic        ld_change;
		logic        upd_peak;
		logic        upd_pos;
		logic        ld_scaled;
		logic        emit;
		jump_t       jump;
		logic [2:0]  target;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input logic [2:0] step);
		ctrl_t c;
		c = '{mul: MUL_NONE, ld_fac: 1'b0, ld_change: 1'b0, upd_peak: 1'b0,
		      upd_pos: 1'b0, ld_scaled: 1'b0, emit: 1'b0, jump: JMP_NEXT,
		      target: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				c.jump   = JMP_START;
				c.target = STEP_FETCH;
			end
			STEP_FETCH: begin
				c.ld_fac = 1'b1;
				c.target = STEP_AX_DECAY;
			end
			STEP_AX_DECAY: begin
				c.mul       = MUL_DECAY;
				c.ld_change = 1'b1;
				c.target    = STEP_AX_BLEND;
			end
			STEP_AX_BLEND: begin
				c.mul      = MUL_BLEND;
				c.upd_peak = 1'b1;
				c.target   = STEP_AX_POS;
			end
			STEP_AX_POS: begin
				c.upd_pos = 1'b1;
				c.target  = STEP_AX_SCALE;
			end
			STEP_AX_SCALE: begin
				c.mul    = MUL_MAG;
				c.target = STEP_AX_HALF;
			end
			STEP_AX_HALF: begin
				c.mul       = MUL_HALF;
				c.ld_scaled = 1'b1;
				c.target    = STEP_AX_EMIT;
			end
			STEP_AX_EMIT: begin
				c.emit   = 1'b1;
				c.jump   = JMP_EMIT;
				c.target = STEP_AX_DECAY;
			end
			default: begin
				c.target = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

>>> rtl/tphs_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module tphs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tilt_peak_hold_smoother_core.sv
// top level: microcoded per-axis peak hold and smoothed tilt readout
`timescale 1ns / 1ps

// Input beats carry three signed Q(F) tilt samples and elapsed milliseconds on
// s_tdata, with the sensor status bit on s_tuser. A beat with status low is
// taken and produces nothing. A good beat produces one result
// beat per axis, in axis order, m_tlast on the final axis, axis number on
// m_tuser.
// After reset the block fills two factor tables, one entry a cycle; s_tready
// stays low until all DECAY_TABLE_DEPTH entries are in (1024 at the default).
// Registers return to their reset values; per-axis state clears to zero.
// A good item runs a fetch step, then decay, blend, position, scale, half
// and emit steps for each axis in turn: one shared multiplier runs four
// products per axis, sequenced by an 8-step control store. Results sit in
// an output register; if the receiver stalls the sequencer waits in its
// emit step and resumes when the beat is taken. The next input beat is taken
// once the last axis is in the output register.
// Configuration writes land at once and are meant for idle periods.

module tilt_peak_hold_smoother_core #(
	parameter int SAMPLE_FRAC_BITS  = 12,
	parameter int DECAY_TABLE_DEPTH = 1024,
	parameter int AXES              = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample_x, sample_y, sample_z, delta_ms
	input  logic        s_tuser,   // sample_valid
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // bar_start, bar_end, negative, whole_g, hundredths, pad
	output logic [1:0]  m_tuser,   // axis
	output logic        m_tlast
);

	localparam int AW       = $clog2(DECAY_TABLE_DEPTH);
	localparam int AXW      = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int POS_FRAC = SAMPLE_FRAC_BITS + tphs_pkg::POS_EXTRA_BITS;
	localparam int MAG_W    = 22 - SAMPLE_FRAC_BITS;
	localparam int SUM_W    = ((MAG_W > 10) ? MAG_W : 10) + 2;
	localparam int WH_W     = tphs_pkg::POS_W - POS_FRAC;
	localparam int WH_X     = (WH_W > 4) ? WH_W : 4;
	localparam int PW       = tphs_pkg::PROD_W;

	// configuration registers
	logic [7:0]  min_hw_q;
	logic [9:0]  bar_limit_q;
	logic [14:0] peak_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hw_q    <= tphs_pkg::MIN_HALF_WIDTH_RST;
			bar_limit_q <= tphs_pkg::BAR_LIMIT_RST;
			peak_cap_q  <= tphs_pkg::PEAK_CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tphs_pkg::CFG_MIN_HALF_WIDTH: min_hw_q    <= cfg_wdata[7:0];
				tphs_pkg::CFG_BAR_LIMIT:      bar_limit_q <= cfg_wdata[9:0];
				tphs_pkg::CFG_PEAK_CAP:       peak_cap_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// factor table fill after reset
	logic          init_busy_q;
	logic          init_first_q;
	logic [AW-1:0] init_addr_q;
	logic [31:0]   p_dec_q;
	logic [31:0]   p_keep_q;
	logic [63:0]   p_dec_prod;
	logic [63:0]   p_keep_prod;
	logic [32:0]   p_dec_rnd;
	logic [32:0]   p_keep_rnd;
	logic [tphs_pkg::FAC_W-1:0] dec_wdata;
	logic [tphs_pkg::FAC_W-1:0] keep_wdata;

	assign p_dec_prod  = 64'(p_dec_q) * 64'(tphs_pkg::DECAY_RATIO_Q32) + 64'h8000_0000;
	assign p_keep_prod = 64'(p_keep_q) * 64'(tphs_pkg::BLEND_RATIO_Q32) + 64'h8000_0000;
	assign p_dec_rnd   = {1'b0, p_dec_q} + 33'h8000;
	assign p_keep_rnd  = {1'b0, p_keep_q} + 33'h8000;
	assign dec_wdata   = init_first_q ? tphs_pkg::ONE_Q16 : p_dec_rnd[32:16];
	assign keep_wdata  = init_first_q ? tphs_pkg::ONE_Q16 : p_keep_rnd[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q  <= 1'b1;
			init_first_q <= 1'b1;
			init_addr_q  <= '0;
		end else if (init_busy_q) begin
			init_first_q <= 1'b0;
			init_addr_q  <= init_addr_q + AW'(1);
			if (init_addr_q == AW'(DECAY_TABLE_DEPTH - 1)) begin
				init_busy_q <= 1'b0;
			end
		end
	end

	// recurrence p(t+1) = round(p(t) * ratio); p(1) is the ratio itself
	always_ff @(posedge clk) begin
		if (init_busy_q) begin
			p_dec_q  <= init_first_q ? tphs_pkg::DECAY_RATIO_Q32 : p_dec_prod[63:32];
			p_keep_q <= init_first_q ? tphs_pkg::BLEND_RATIO_Q32 : p_keep_prod[63:32];
		end
	end

	// factor tables, read at the elapsed time of the beat being taken
	logic [tphs_pkg::FAC_W-1:0] dec_rdata;
	logic [tphs_pkg::FAC_W-1:0] keep_rdata;

	tphs_ram #(.WIDTH(tphs_pkg::FAC_W), .DEPTH(DECAY_TABLE_DEPTH)) u_decay_ram (
		.clk   (clk),
		.we    (init_busy_q),
		.waddr (init_addr_q),
		.wdata (dec_wdata),
		.raddr (s_tdata[48 +: AW]),
		.rdata (dec_rdata)
	);

	tphs_ram #(.WIDTH(tphs_pkg::FAC_W), .DEPTH(DECAY_TABLE_DEPTH)) u_keep_ram (
		.clk   (clk),
		.we    (init_busy_q),
		.waddr (init_addr_q),
		.wdata (keep_wdata),
		.raddr (s_tdata[48 +: AW]),
		.rdata (keep_rdata)
	);

	// sequencer
	logic [2:0]      upc_q;
	logic [1:0]      axis_q;
	tphs_pkg::ctrl_t ctrl;
	logic            in_fire;
	logic            out_free;
	logic            emit_fire;
	logic            axis_last;

	assign ctrl      = tphs_pkg::ucode(upc_q);
	assign s_tready  = !init_busy_q && (upc_q == tphs_pkg::STEP_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign emit_fire = ctrl.emit && out_free;
	assign axis_last = (axis_q == 2'(AXES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= tphs_pkg::STEP_IDLE;
			axis_q <= '0;
		end else begin
			case (ctrl.jump)
				tphs_pkg::JMP_START: begin
					if (in_fire && s_tuser) begin
						upc_q <= ctrl.target;
					end
				end
				tphs_pkg::JMP_EMIT: begin
					if (out_free) begin
						upc_q <= axis_last ? tphs_pkg::STEP_IDLE : ctrl.target;
					end
				end
				default: begin
					upc_q <= ctrl.target;
				end
			endcase
			if (ctrl.ld_fac) begin
				axis_q <= '0;
			end else if (emit_fire && !axis_last) begin
				axis_q <= axis_q + 2'd1;
			end
		end
	end

	// latched input beat
	logic [tphs_pkg::SAMPLE_W-1:0] sample_q [AXES];
	logic                          in_range_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < AXES; i++) begin
				sample_q[i] <= s_tdata[16*i +: 16];
			end
			in_range_q <= (s_tdata[63:48] < 16'(DECAY_TABLE_DEPTH));
		end
	end

	// per-axis state
	logic [15:0]               prev_q [AXES];
	logic [15:0]               held_q [AXES];
	logic [tphs_pkg::POS_W-1:0] pos_q [AXES];
	logic [AXW-1:0]            ax;

	assign ax = axis_q[AXW-1:0];

	// datapath registers
	logic [tphs_pkg::FAC_W-1:0] fac_decay_q;
	logic [tphs_pkg::FAC_W-1:0] fac_blend_q;
	logic [15:0]                change_q;
	logic [15:0]                peak_q;
	logic                       neg_q;
	logic [tphs_pkg::POS_W-1:0] mag_q;
	logic [MAG_W-1:0]           scaled_q;
	logic signed [PW-1:0]       prod_q;

	// shared multiplier operands
	logic signed [tphs_pkg::MUL_A_W-1:0] mul_a;
	logic signed [tphs_pkg::MUL_B_W-1:0] mul_b;
	logic        [15:0]                  s_cur;
	logic        [tphs_pkg::POS_W-1:0]   pos_cur;
	logic signed [24:0]                  diff;

	assign s_cur   = sample_q[ax];
	assign pos_cur = pos_q[ax];
	assign diff    = signed'({s_cur[15], s_cur, 8'b0}) - signed'({pos_cur[23], pos_cur});

	always_comb begin
		case (ctrl.mul)
			tphs_pkg::MUL_DECAY: begin
				mul_a = signed'({10'b0, held_q[ax]});
				mul_b = signed'({1'b0, fac_decay_q});
			end
			tphs_pkg::MUL_BLEND: begin
				mul_a = tphs_pkg::MUL_A_W'(diff);
				mul_b = signed'({1'b0, fac_blend_q});
			end
			tphs_pkg::MUL_MAG: begin
				mul_a = signed'({2'b0, mag_q});
				mul_b = 18'sd100;
			end
			tphs_pkg::MUL_HALF: begin
				mul_a = signed'({10'b0, peak_q});
				mul_b = 18'sd100;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// change, decayed peak, cap and position update
	logic signed [16:0]         sdiff;
	logic [15:0]                change;
	logic signed [PW-1:0]       prod_rnd;
	logic [15:0]                decayed;
	logic [15:0]                peak_max;
	logic [15:0]                peak_new;
	logic signed [24:0]         pos_inc;
	logic signed [24:0]         pos_sum;
	logic [tphs_pkg::POS_W-1:0] pos_new;

	assign sdiff    = signed'({s_cur[15], s_cur}) - signed'({prev_q[ax][15], prev_q[ax]});
	assign change   = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
	assign prod_rnd = prod_q + PW'(32768);
	assign decayed  = prod_rnd[31:16];
	assign peak_max = (change_q > decayed) ? change_q : decayed;
	assign peak_new = (peak_max > {1'b0, peak_cap_q}) ? {1'b0, peak_cap_q} : peak_max;
	assign pos_inc  = prod_rnd[40:16];
	assign pos_sum  = signed'({pos_cur[23], pos_cur}) + pos_inc;
	assign pos_new  = pos_sum[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				prev_q[i] <= '0;
				held_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (ctrl.upd_peak) begin
				held_q[ax] <= peak_new;
				prev_q[ax] <= s_cur;
			end
			if (ctrl.upd_pos) begin
				pos_q[ax] <= pos_new;
			end
		end
	end

	// product holds through steps that do not use the multiplier
	always_ff @(posedge clk) begin
		if (ctrl.mul != tphs_pkg::MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctrl.ld_fac) begin
			fac_decay_q <= in_range_q ? dec_rdata : '0;
			fac_blend_q <= in_range_q ? (tphs_pkg::ONE_Q16 - keep_rdata) : tphs_pkg::ONE_Q16;
		end
		if (ctrl.ld_change) begin
			change_q <= change;
		end
		if (ctrl.upd_peak) begin
			peak_q <= peak_new;
		end
		if (ctrl.upd_pos) begin
			neg_q <= pos_new[23];
			mag_q <= pos_new[23] ? tphs_pkg::POS_W'(-pos_new) : pos_new;
		end
		if (ctrl.ld_scaled) begin
			scaled_q <= prod_q[POS_FRAC +: MAG_W];
		end
	end

	// bar ends and readout
	logic [MAG_W-1:0]        half_raw;
	logic [MAG_W-1:0]        half;
	logic signed [SUM_W-1:0] lim_s;
	logic signed [SUM_W-1:0] center;
	logic signed [SUM_W-1:0] half_s;
	logic signed [SUM_W-1:0] lo;
	logic signed [SUM_W-1:0] hi;
	logic signed [SUM_W-1:0] lo_c;
	logic signed [SUM_W-1:0] hi_c;
	logic [WH_W-1:0]         whole_full;
	logic [WH_X-1:0]         whole_ext;
	logic [3:0]              whole_g;
	logic [MAG_W-1:0]        hund_full;

	assign half_raw   = prod_q[SAMPLE_FRAC_BITS +: MAG_W];
	assign half       = (half_raw < MAG_W'(min_hw_q)) ? MAG_W'(min_hw_q) : half_raw;
	assign lim_s      = signed'(SUM_W'(bar_limit_q));
	assign half_s     = signed'(SUM_W'(half));
	assign center     = neg_q ? -signed'(SUM_W'(scaled_q)) : signed'(SUM_W'(scaled_q));
	assign lo         = center - half_s;
	assign hi         = center + half_s;
	assign lo_c       = (lo > lim_s) ? lim_s : ((lo < -lim_s) ? -lim_s : lo);
	assign hi_c       = (hi > lim_s) ? lim_s : ((hi < -lim_s) ? -lim_s : hi);
	assign whole_full = mag_q[POS_FRAC +: WH_W];
	assign whole_ext  = WH_X'(whole_full);
	assign whole_g    = (whole_ext > WH_X'(15)) ? 4'd15 : whole_ext[3:0];
	assign hund_full  = scaled_q - MAG_W'(MAG_W'(whole_full) * MAG_W'(100));

	// output register
	logic [10:0] bar_start_q;
	logic [10:0] bar_end_q;
	logic        out_neg_q;
	logic [3:0]  whole_q;
	logic [6:0]  hund_q;
	logic [1:0]  out_axis_q;
	logic        out_last_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			bar_start_q <= 11'(lo_c);
			bar_end_q   <= 11'(hi_c);
			out_neg_q   <= neg_q;
			whole_q     <= whole_g;
			hund_q      <= 7'(hund_full);
			out_axis_q  <= axis_q;
			out_last_q  <= axis_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, hund_q, whole_q, out_neg_q, bar_end_q, bar_start_q};
	assign m_tuser  = out_axis_q;
	assign m_tlast  = out_last_q;

	// checks
	a_no_result_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy_q |-> !m_tvalid)
		else $error("result beat during table fill");

	a_good_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser) |=> (upc_q == tphs_pkg::STEP_FETCH))
		else $error("good input beat did not start the sequence");

	a_peak_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == tphs_pkg::STEP_AX_POS) |-> (peak_q <= {1'b0, peak_cap_q}))
		else $error("held peak above cap");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q < 2'(AXES))
		else $error("axis counter out of range");

endmodule
